// ----- src/atkbd_pkg.sv -----
// ----------------------------------------------------------------------------
// atkbd_pkg
// Shared types, constants and the frame bit function of the AT keyboard
// frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package atkbd_pkg;

	localparam int BYTE_W = 8;
	localparam int STEP_W = 7;
	localparam int COUNT_W = 6;

	// Frame timing, in ticks.
	localparam logic [STEP_W-1:0] BIT_TICKS_END   = 7'd44;
	localparam logic [STEP_W-1:0] FRAME_LAST_STEP = 7'd93;
	localparam logic [STEP_W-1:0] LAST_DATA_STEP  = 7'd32;
	localparam logic [STEP_W-1:0] PARITY_STEP     = 7'd36;

	// Position of a tick inside one four-tick bit cell.
	localparam logic [1:0] PHASE_DATA      = 2'd0;
	localparam logic [1:0] PHASE_CLK_LOW   = 2'd1;
	localparam logic [1:0] PHASE_CLK_HIGH  = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_FLUSH = 2'd2
	} opcode_t;

	// Data line level set at the first tick of a bit cell.
	function automatic logic frame_data_bit(input logic [STEP_W-1:0] step,
		input logic [BYTE_W-1:0] b);
		logic [3:0] k;
		logic       bit_val;
		k = step[5:2] - 4'd1;
		if (step == '0) begin
			bit_val = 1'b0;
		end else if (step <= LAST_DATA_STEP) begin
			bit_val = b[k[2:0]];
		end else if (step == PARITY_STEP) begin
			bit_val = ~(^b);
		end else begin
			bit_val = 1'b1;
		end
		return bit_val;
	endfunction

endpackage

`default_nettype wire

// ----- src/atkbd_queue_ram.sv -----
// ----------------------------------------------------------------------------
// atkbd_queue_ram
// Byte queue storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module atkbd_queue_ram
	import atkbd_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data holds while rd_en is low, so a stalled request keeps it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/at_keyboard_frame_transmitter_top.sv -----
// ----------------------------------------------------------------------------
// at_keyboard_frame_transmitter_top
// Device-side AT keyboard transmitter with a byte queue in block memory.
// ----------------------------------------------------------------------------
// Each request carries an opcode on s_tuser: a tick of the 20 us bit timer,
// a byte push, or a flush of the queue. Pushed bytes wait in a circular
// queue of QUEUE_DEPTH entries held in a synchronous memory; a push to a
// full queue is refused and reported. A tick starts a frame only when a
// byte is waiting and both sensed bus lines are high, and from then on the
// sensed lines are ignored. A frame is 94 ticks: start bit, eight data bits
// least significant first, odd parity and stop bit, four ticks per bit with
// the clock driven low on the second tick and released on the fourth, then
// a 50-tick idle pause after which the byte leaves the queue. A flush empties
// the queue and restarts the frame but leaves both driven line levels as
// they are. Every request produces exactly one response on m_tdata carrying
// the driven line levels, whether the push was stored, the fill count and
// whether a frame is in progress. The block takes one request per clock
// cycle while the response side keeps up, and each response is built in stages:
// the first stage updates pointers, count and clock level while the memory
// reads the byte at the queue head, and the second forms the data level from
// the registered read data into the output register. A response waiting on
// m_tready stalls a full first stage, and s_tready then follows m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module at_keyboard_frame_transmitter_top
	import atkbd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request side.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata from bit 0: push_byte[7:0], clock_line_sense, data_line_sense.
	input  wire logic [15:0] s_tdata,
	// s_tuser: opcode[1:0].
	input  wire logic [1:0]  s_tuser,
	// Response side.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata from bit 0: clock_drive, data_drive, push_accepted,
	// queued_bytes[5:0], frame_active.
	output logic      [15:0] m_tdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] DEPTH_FILL = FW'(QUEUE_DEPTH);

	// Unpacked request fields.
	opcode_t           op;
	logic [BYTE_W-1:0] push_byte;
	logic              clock_line_sense;
	logic              data_line_sense;

	assign op               = opcode_t'(s_tuser);
	assign push_byte        = s_tdata[7:0];
	assign clock_line_sense = s_tdata[8];
	assign data_line_sense  = s_tdata[9];

	// Architectural state.
	logic [AW-1:0]     head_q;
	logic [FW-1:0]     fill_q;
	logic [STEP_W-1:0] step_q;
	logic              clock_q;
	logic              data_q;

	// Next state and per-request flags, worked out in the accept cycle.
	logic [AW-1:0]     head_d;
	logic [FW-1:0]     fill_d;
	logic [STEP_W-1:0] step_d;
	logic              clock_d;
	logic              accepted;
	logic              data_upd;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW:0]       wr_sum;
	logic [AW-1:0]     head_inc;
	logic              tick_go;

	// First stage registers.
	logic              valid_s1;
	logic              data_upd_s1;
	logic [STEP_W-1:0] step_s1;
	logic              clock_s1;
	logic              accepted_s1;
	logic [COUNT_W-1:0] count_s1;
	logic              active_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	// Output register.
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	logic              accept;
	logic              adv1;
	logic              data_new;
	logic [FW+COUNT_W-1:0] fill_ext;

	assign adv1     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv1;
	assign accept   = s_tvalid && s_tready;

	// Tail slot of the queue, wrapped without a divider.
	assign wr_sum   = {1'b0, head_q} + (AW + 1)'(fill_q[AW-1:0]);
	assign wr_addr  = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : wr_sum[AW-1:0];
	assign head_inc = (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;

	assign tick_go = (fill_q != '0) &&
		!((step_q == '0) && !(clock_line_sense && data_line_sense));

	always_comb begin
		head_d   = head_q;
		fill_d   = fill_q;
		step_d   = step_q;
		clock_d  = clock_q;
		accepted = 1'b0;
		data_upd = 1'b0;
		wr_en    = 1'b0;
		case (op)
			OP_TICK: begin
				if (tick_go) begin
					if (step_q < BIT_TICKS_END) begin
						case (step_q[1:0])
							PHASE_DATA:     data_upd = 1'b1;
							PHASE_CLK_LOW:  clock_d = 1'b0;
							PHASE_CLK_HIGH: clock_d = 1'b1;
							default:        ;
						endcase
					end
					if (step_q == FRAME_LAST_STEP) begin
						// End of the idle pause: the byte leaves the queue.
						step_d = '0;
						head_d = head_inc;
						fill_d = fill_q - 1'b1;
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			OP_PUSH: begin
				if (fill_q < DEPTH_FILL) begin
					wr_en    = 1'b1;
					fill_d   = fill_q + 1'b1;
					accepted = 1'b1;
				end
			end
			OP_FLUSH: begin
				head_d = '0;
				fill_d = '0;
				step_d = '0;
			end
			default: ;
		endcase
	end

	// A push writes the tail while a tick reads the head. They never hit the
	// same entry when the read matters: a tick reads only a non-empty queue,
	// and a push lands beyond the last stored byte.
	atkbd_queue_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_byte),
		.rd_en   (accept),
		.rd_addr (head_q),
		.rd_data (rd_data_s1)
	);

	assign fill_ext = {{COUNT_W{1'b0}}, fill_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			step_q   <= '0;
			clock_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				fill_q  <= fill_d;
				step_q  <= step_d;
				clock_q <= clock_d;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_upd_s1 <= data_upd;
			step_s1     <= step_q;
			clock_s1    <= clock_d;
			accepted_s1 <= accepted;
			count_s1    <= fill_ext[COUNT_W-1:0];
			active_s1   <= (step_d != '0);
		end
	end

	// Second stage: the data level needs the byte read from the queue head.
	assign data_new = data_upd_s1 ? frame_data_bit(step_s1, rd_data_s1) : data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q    <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				data_q    <= data_new;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			m_data_q <= {6'd0, active_s1, count_s1, accepted_s1, data_new, clock_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire
